### design/quaternion_mandelbrot_escape_macros.svh
// assertion macros used by the checker file
`ifndef QUATERNION_MANDELBROT_ESCAPE_MACROS_SVH
`define QUATERNION_MANDELBROT_ESCAPE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define QME_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define QME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/qme_pkg.sv
// ---------------------------------------------------------------------------
// qme_pkg
// shared types and codes of the quaternion escape-time unit
// ---------------------------------------------------------------------------
package qme_pkg;

  // width of the escape step field in the result word
  localparam int STEPS_W = 12;
  // config bus address width and register index
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_LIMIT = '0;

  // outcome codes
  localparam logic [1:0] OUT_ESCAPED = 2'd0;
  localparam logic [1:0] OUT_FIXED   = 2'd1;
  localparam logic [1:0] OUT_LIMIT   = 2'd2;

  // input word: point c in signed fixed point
  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_i;
    logic signed [31:0] c_j;
    logic signed [31:0] c_k;
  } in_item_t;

  // result word
  typedef struct packed {
    logic [1:0]         outcome;
    logic [STEPS_W-1:0] escape_steps;
  } out_item_t;

  // product selected for the shared multiplier
  typedef enum logic [2:0] {
    T_AA, T_BB, T_CC, T_DD, T_AB, T_AC, T_AD
  } term_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_MUL, S_DRAIN, S_EVAL, S_FINISH
  } st_t;

  // controller to datapath commands
  typedef struct packed {
    logic  load;
    logic  acc_init;
    logic  mul_en;
    term_t mul_term;
    logic  update_z;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic fixed_pt;
    logic escaped;
  } dp_sts_t;

endpackage

### design/qme_datapath.sv
// ---------------------------------------------------------------------------
// qme_datapath
// iterate registers, shared 32x32 multiplier, lane accumulators, saturation
// and the fixed-point and escape tests
// ---------------------------------------------------------------------------
module qme_datapath
  import qme_pkg::*;
#(
  parameter int FRAC_BITS = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_item_t in_data,
  input  dp_cmd_t  cmd,
  output dp_sts_t  sts
);

  localparam logic signed [31:0] BOUND     = 32'sd2 <<< FRAC_BITS;
  localparam logic signed [31:0] NEG_BOUND = -BOUND;
  localparam logic signed [63:0] S32_MAX   = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN   = -64'sd2147483648;

  logic signed [31:0] c_r [4];
  logic signed [31:0] z_r [4];
  logic signed [63:0] acc_r [4];
  logic signed [63:0] prod_r;
  term_t              prod_term_r;
  logic               prod_vld_r;

  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod_nxt;
  logic signed [63:0] sq_term, cross_term;
  logic signed [31:0] nz [4];

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.mul_term)
      T_AA: begin op_a = z_r[0]; op_b = z_r[0]; end
      T_BB: begin op_a = z_r[1]; op_b = z_r[1]; end
      T_CC: begin op_a = z_r[2]; op_b = z_r[2]; end
      T_DD: begin op_a = z_r[3]; op_b = z_r[3]; end
      T_AB: begin op_a = z_r[0]; op_b = z_r[1]; end
      T_AC: begin op_a = z_r[0]; op_b = z_r[2]; end
      T_AD: begin op_a = z_r[0]; op_b = z_r[3]; end
      default: begin op_a = z_r[0]; op_b = z_r[0]; end
    endcase
  end

  assign prod_nxt = 64'(op_a) * 64'(op_b);

  // floor scaling: squares by the fraction, cross terms carry the factor two
  assign sq_term    = prod_r >>> FRAC_BITS;
  assign cross_term = prod_r >>> (FRAC_BITS - 1);

  // product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul_en;
    end
    if (cmd.mul_en) begin
      prod_r      <= prod_nxt;
      prod_term_r <= cmd.mul_term;
    end
  end

  // lane accumulators, seeded with c at the start of each iteration
  always_ff @(posedge clk) begin
    if (cmd.acc_init) begin
      for (int i = 0; i < 4; i++) begin
        acc_r[i] <= 64'(c_r[i]);
      end
    end else if (prod_vld_r) begin
      case (prod_term_r)
        T_AA:    acc_r[0] <= acc_r[0] + sq_term;
        T_BB:    acc_r[0] <= acc_r[0] - sq_term;
        T_CC:    acc_r[0] <= acc_r[0] - sq_term;
        T_DD:    acc_r[0] <= acc_r[0] - sq_term;
        T_AB:    acc_r[1] <= acc_r[1] + cross_term;
        T_AC:    acc_r[2] <= acc_r[2] + cross_term;
        T_AD:    acc_r[3] <= acc_r[3] + cross_term;
        default: acc_r[0] <= acc_r[0];
      endcase
    end
  end

  // saturate each lane to 32 bits
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (acc_r[i] > S32_MAX) begin
        nz[i] = 32'sh7fffffff;
      end else if (acc_r[i] < S32_MIN) begin
        nz[i] = 32'sh80000000;
      end else begin
        nz[i] = acc_r[i][31:0];
      end
    end
  end

  // point and iterate registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r[0] <= in_data.c_real;
      c_r[1] <= in_data.c_i;
      c_r[2] <= in_data.c_j;
      c_r[3] <= in_data.c_k;
      for (int i = 0; i < 4; i++) begin
        z_r[i] <= '0;
      end
    end else if (cmd.update_z) begin
      for (int i = 0; i < 4; i++) begin
        z_r[i] <= nz[i];
      end
    end
  end

  // status for the controller
  assign sts.fixed_pt = (nz[0] == z_r[0]) && (nz[1] == z_r[1]) &&
                        (nz[2] == z_r[2]) && (nz[3] == z_r[3]);
  assign sts.escaped  = (nz[0] > BOUND) || (nz[0] < NEG_BOUND);

endmodule

### design/qme_ctrl.sv
// ---------------------------------------------------------------------------
// qme_ctrl
// sequencer for one point: step count, product schedule, result register
// ---------------------------------------------------------------------------
module qme_ctrl
  import qme_pkg::*;
#(
  parameter int MAX_ITER_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,
  input  logic [MAX_ITER_BITS-1:0] limit,
  output dp_cmd_t                  cmd,
  input  dp_sts_t                  sts
);

  st_t                      state_r, state_nxt;
  term_t                    term_r, term_nxt;
  logic [MAX_ITER_BITS-1:0] cnt_r, cnt_nxt;
  logic [1:0]               outcome_r, outcome_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_item_r, out_item_nxt;

  logic [31:0]              cnt_ext;
  logic                     out_free;

  assign cnt_ext  = 32'(cnt_r);
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_CHECK;
      S_CHECK:  state_nxt = (cnt_r < limit) ? S_MUL : S_FINISH;
      S_MUL:    if (term_r == T_AD) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = S_EVAL;
      S_EVAL:   state_nxt = (sts.fixed_pt || sts.escaped) ? S_FINISH : S_CHECK;
      S_FINISH: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.mul_term  = term_r;
    term_nxt      = term_r;
    cnt_nxt       = cnt_r;
    outcome_nxt   = outcome_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_nxt  = '0;
        end
      end
      S_CHECK: begin
        if (cnt_r < limit) begin
          cmd.acc_init = 1'b1;
          term_nxt     = T_AA;
        end else begin
          outcome_nxt = OUT_LIMIT;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (term_r != T_AD) term_nxt = term_t'(term_r + 3'd1);
      end
      S_DRAIN: begin
        cmd.mul_en = 1'b0;
      end
      S_EVAL: begin
        if (sts.fixed_pt) begin
          outcome_nxt = OUT_FIXED;
        end else begin
          cmd.update_z = 1'b1;
          if (sts.escaped) begin
            outcome_nxt = OUT_ESCAPED;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_item_nxt.outcome = outcome_r;
          out_item_nxt.escape_steps =
            (outcome_r == OUT_ESCAPED) ? cnt_ext[STEPS_W-1:0] : '0;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    term_r     <= term_nxt;
    cnt_r      <= cnt_nxt;
    outcome_r  <= outcome_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

### design/quaternion_mandelbrot_escape.sv
// ---------------------------------------------------------------------------
// quaternion_mandelbrot_escape
// escape-time unit for the quaternion Mandelbrot set in signed fixed point
// ---------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one point c per word;
//   out channel (out_valid/out_ready/out_data) returns outcome and escape step.
//   iteration_limit sits at byte address 0 of the APB port; write it only
//   while the unit is idle.
// Timing:
//   one point is worked at a time. Each iteration runs one check, seven
//   products through the single shared 32x32 multiplier, one drain and one
//   evaluate. The unit returns to idle, ready for the next point, as the
//   result is written to the output register.
// Reset:
//   synchronous active-low rst_n returns to idle, drops out_valid and sets
//   iteration_limit to 64.
// Stall:
//   the result waits in the output register; a new point is accepted while
//   it waits, and that point's result holds until the old one is taken.
// ---------------------------------------------------------------------------
module quaternion_mandelbrot_escape
  import qme_pkg::*;
#(
  parameter int MAX_ITER_BITS = 12,
  parameter int FRAC_BITS     = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [MAX_ITER_BITS-1:0] limit_r, limit_nxt;
  logic [ADDR_W-3:0]        reg_idx;
  logic                     wr_en;
  dp_cmd_t                  cmd;
  dp_sts_t                  sts;

  // config register
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && (reg_idx == REG_LIMIT);
  assign limit_nxt = wr_en ? pwdata[MAX_ITER_BITS-1:0] : limit_r;
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_LIMIT) ? 32'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= MAX_ITER_BITS'(64);
    end else begin
      limit_r <= limit_nxt;
    end
  end

  qme_ctrl #(
    .MAX_ITER_BITS(MAX_ITER_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .limit    (limit_r),
    .cmd      (cmd),
    .sts      (sts)
  );

  qme_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_data(in_data),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

### design/qme_checker.sv
// ---------------------------------------------------------------------------
// qme_checker
// port-level checks on the escape-time unit, bound to the top level
// ---------------------------------------------------------------------------
`include "quaternion_mandelbrot_escape_macros.svh"

module qme_checker
  import qme_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      pready
);

  // a stalled result word holds
  `QME_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // escape step is only reported for escaped points
  `QME_ASSERT_SAME(a_steps_zero, out_valid && (out_data.outcome != OUT_ESCAPED), out_data.escape_steps == '0, "nonzero steps without escape")

  // one point at a time: busy right after accepting a word
  `QME_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "accepted a second point while busy")

  // config port never inserts wait states
  `QME_ASSERT_SAME(a_pready, 1'b1, pready, "pready dropped")

endmodule

bind quaternion_mandelbrot_escape qme_checker u_qme_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data),
  .pready   (pready)
);
